FILE: design/bre_pkg.sv
// Package: request, status and policy codes plus payload structs.
`timescale 1ns / 1ps
package bre_pkg;
    localparam logic [2:0] REQ_DEFINE = 3'd0;
    localparam logic [2:0] REQ_LOAD   = 3'd1;
    localparam logic [2:0] REQ_UNLOAD = 3'd2;
    localparam logic [2:0] REQ_RANK   = 3'd3;
    localparam logic [2:0] REQ_DEP    = 3'd4;
    localparam logic [2:0] REQ_BUDGET = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_NOVICT   = 3'd2;
    localparam logic [2:0] ST_DEPS     = 3'd3;
    localparam logic [2:0] ST_FETCH    = 3'd4;
    localparam logic [2:0] ST_ZEROBUD  = 3'd5;

    localparam logic [1:0] POL_OLDEST = 2'd0;
    localparam logic [1:0] POL_COUNT  = 2'd1;
    localparam logic [1:0] POL_RANK   = 2'd2;
    localparam logic [1:0] POL_INDEX  = 2'd3;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_EVICT  = 2'd1;
    localparam logic [1:0] CFG_DEPCHK = 2'd2;

    localparam logic [31:0] RESET_BUDGET = 32'd1073741824;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  entry;
        logic [3:0]  other_entry;
        logic [31:0] amount;
        logic [15:0] rank;
        logic        fetch_ok;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        evicted_valid;
        logic [3:0]  evicted_entry;
        logic [35:0] used_bytes;
        logic [35:0] peak_bytes;
        logic        last;
    } t_rsp;
endpackage

FILE: design/budgeted_residency_evictor_core.sv
// Budgeted residency evictor: entry table, request sequencer and victim scan.
`timescale 1ns / 1ps
// Each request passes through a table read (synchronous memory), a decision step and a result
// transfer. A load or budget cut that must evict runs a victim scan that reads the entry memory
// once per entry, then drops the victim and hands over its result; it emits one result per
// victim. After reset a clearing pass over every entry resets the attribute memory; no request
// is accepted during it. The resident flags and dependents bits sit in flip-flops, so the
// dependency check is a plain AND of two vectors. Results leave through one output register.
module budgeted_residency_evictor_core
    import bre_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [1:0]  i_cfg_data
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic [31:0] size;
        logic [31:0] stamp;
        logic [31:0] total;
        logic [15:0] rank;
    } t_ent;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_EXEC  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_DROP  = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;
    localparam logic [3:0] S_RDV   = 4'd7;
    localparam logic [3:0] S_DROPW = 4'd8;

    t_ent r_mem [ENTRIES];
    t_ent r_rd;
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    t_ent            mem_wd;
    logic [IW-1:0]   mem_ra;

    logic [3:0]        r_state, n_state;
    logic [ENTRIES-1:0] r_res, n_res;
    logic [ENTRIES-1:0] r_deps [ENTRIES];
    logic [31:0]       r_stamp, n_stamp;
    logic [36:0]       r_used, n_used;
    logic [36:0]       r_peak, n_peak;
    logic [31:0]       r_budget, n_budget;
    logic [1:0]        r_pol;
    logic              r_ev_en, r_dep_en;
    t_req              r_req, n_req;
    t_ent              r_cur, n_cur;
    logic [CW-1:0]     r_scan, n_scan;
    logic              r_sfirst, r_sstart, n_sfirst, n_sstart;
    logic              r_bvalid, n_bvalid;
    logic [IW-1:0]     r_best, n_best;
    logic [31:0]       r_bkey, n_bkey;
    logic [IW-1:0]     r_sidx, n_sidx;
    logic              r_ovalid, n_ovalid;
    t_rsp              r_rsp, n_rsp;
    t_rsp              r_pend, n_pend;
    logic              r_ret, n_ret;
    logic              dep_we;

    logic [IW-1:0] e_idx, o_idx;
    logic          e_ok, o_ok;
    assign e_idx = IW'(r_req.entry);
    assign o_idx = IW'(r_req.other_entry);
    assign e_ok  = {28'd0, r_req.entry} < 32'(ENTRIES);
    assign o_ok  = {28'd0, r_req.other_entry} < 32'(ENTRIES);

    function automatic logic evictable(input logic [ENTRIES-1:0] res,
                                       input logic [ENTRIES-1:0] deps,
                                       input logic chk, input logic [IW-1:0] i);
        return res[i] && !(chk && ((deps & res) != '0));
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) r_deps[k] <= '0;
        end else if (dep_we) begin
            r_deps[o_idx] <= r_deps[o_idx] | (ENTRIES'(1) << e_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol <= POL_OLDEST;
            r_ev_en <= 1'b1;
            r_dep_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POLICY: r_pol <= i_cfg_data;
                CFG_EVICT:  r_ev_en <= i_cfg_data[0];
                CFG_DEPCHK: r_dep_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_res    <= '0;
            r_stamp  <= '0;
            r_used   <= '0;
            r_peak   <= '0;
            r_budget <= RESET_BUDGET;
            r_scan   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_res    <= n_res;
            r_stamp  <= n_stamp;
            r_used   <= n_used;
            r_peak   <= n_peak;
            r_budget <= n_budget;
            r_scan   <= n_scan;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_cur <= n_cur;
        r_sfirst <= n_sfirst;
        r_sstart <= n_sstart;
        r_bvalid <= n_bvalid;
        r_best <= n_best;
        r_bkey <= n_bkey;
        r_sidx <= n_sidx;
        r_rsp <= n_rsp;
        r_pend <= n_pend;
        r_ret <= n_ret;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    logic [36:0] need;
    logic [31:0] key;
    logic        cand, better;
    logic [IW-1:0] sidx;

    always_comb begin
        n_state = r_state; n_res = r_res; n_stamp = r_stamp; n_used = r_used;
        n_peak = r_peak; n_budget = r_budget; n_req = r_req; n_cur = r_cur;
        n_scan = r_scan; n_sfirst = r_sfirst; n_sstart = r_sstart;
        n_bvalid = r_bvalid; n_best = r_best; n_bkey = r_bkey; n_sidx = r_sidx;
        n_ovalid = r_ovalid; n_rsp = r_rsp; n_pend = r_pend; n_ret = r_ret;
        mem_we = 1'b0; mem_wa = e_idx; mem_wd = r_cur; mem_ra = e_idx;
        dep_we = 1'b0;
        need = r_used + {5'd0, r_cur.size};
        sidx = r_sidx;
        key = '0; cand = 1'b0; better = 1'b0;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_scan[IW-1:0];
                mem_wd = '0;
                n_scan = r_scan + CW'(1);
                if (r_scan == CW'(ENTRIES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_req = i_req;
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_EXEC;
            S_EXEC: begin
                n_cur = r_rd;
                n_pend = '0;
                n_pend.last = 1'b1;
                n_ret = 1'b0;
                n_state = S_OUT;
                if (r_req.req_type == REQ_DEP) begin
                    if (!e_ok || !o_ok || r_req.entry == r_req.other_entry)
                        n_pend.status = ST_BAD;
                    else dep_we = 1'b1;
                end else if (r_req.req_type > REQ_BUDGET) begin
                    n_pend.status = ST_OK;
                end else if (r_req.req_type == REQ_BUDGET) begin
                    if (r_req.amount == '0) n_pend.status = ST_ZEROBUD;
                    else if (r_used > {5'd0, r_req.amount}) begin
                        n_state = S_SCAN; n_scan = '0; n_sstart = 1'b1;
                    end else n_budget = r_req.amount;
                end else if (!e_ok) begin
                    n_pend.status = ST_BAD;
                end else begin
                    case (r_req.req_type)
                        REQ_DEFINE: begin
                            if (r_res[e_idx]) begin
                                n_used = r_used - {5'd0, r_rd.size}
                                         + {5'd0, r_req.amount};
                                if (n_used > r_peak) n_peak = n_used;
                            end
                            mem_we = 1'b1; mem_wd = r_rd; mem_wd.size = r_req.amount;
                        end
                        REQ_RANK: begin
                            mem_we = 1'b1; mem_wd = r_rd; mem_wd.rank = r_req.rank;
                        end
                        REQ_UNLOAD: begin
                            if (r_res[e_idx]) begin
                                if (!evictable(r_res, r_deps[e_idx], r_dep_en, e_idx))
                                    n_pend.status = ST_DEPS;
                                else begin
                                    n_res[e_idx] = 1'b0;
                                    n_used = r_used - {5'd0, r_rd.size};
                                end
                            end
                        end
                        default: begin
                            // load: resident entries only touch; others go to the fit check
                            if (r_res[e_idx]) begin
                                n_stamp = r_stamp + 32'd1;
                                mem_we = 1'b1; mem_wd = r_rd; mem_wd.stamp = n_stamp;
                                if (r_rd.total != '1) mem_wd.total = r_rd.total + 32'd1;
                            end else begin
                                n_state = S_SCAN; n_scan = '0; n_sstart = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // first visit: decide whether another victim is needed
                if (r_sstart) begin
                    n_sstart = 1'b0;
                    n_sfirst = 1'b1;
                    n_bvalid = 1'b0;
                    n_scan = '0;
                    n_sidx = '0;
                    mem_ra = '0;
                    if (r_req.req_type == REQ_BUDGET) begin
                        if (!(r_used > {5'd0, r_req.amount})) begin
                            n_budget = r_req.amount;
                            n_pend = '0; n_pend.last = 1'b1; n_state = S_OUT;
                        end
                    end else if (!r_ev_en || !(need > {5'd0, r_budget})) begin
                        n_pend = '0; n_pend.last = 1'b1;
                        if (!r_req.fetch_ok) n_pend.status = ST_FETCH;
                        else begin
                            n_res[e_idx] = 1'b1;
                            n_used = need;
                            if (need > r_peak) n_peak = need;
                            n_stamp = r_stamp + 32'd1;
                            mem_we = 1'b1; mem_wd = r_cur; mem_wd.stamp = n_stamp;
                            if (r_cur.total != '1) mem_wd.total = r_cur.total + 32'd1;
                        end
                        n_state = S_OUT;
                    end
                end else begin
                    // r_rd holds entry r_sidx (read issued last cycle)
                    if (!r_sfirst) begin
                        cand = evictable(r_res, r_deps[sidx], r_dep_en, sidx);
                        if (r_req.req_type == REQ_BUDGET) begin
                            key = r_rd.size;
                            cand = cand && (key != '0);
                            better = !r_bvalid || key > r_bkey;
                        end else begin
                            cand = cand && (sidx != e_idx);
                            case (r_pol)
                                POL_OLDEST: key = r_rd.stamp;
                                POL_COUNT:  key = r_rd.total;
                                POL_RANK:   key = {16'd0, r_rd.rank};
                                default:    key = '0;
                            endcase
                            better = !r_bvalid || (r_pol != POL_INDEX && key < r_bkey);
                        end
                        if (cand && better) begin
                            n_bvalid = 1'b1; n_best = sidx; n_bkey = key;
                        end
                    end
                    n_sfirst = 1'b0;
                    n_scan = r_scan + CW'(1);
                    mem_ra = r_scan[IW-1:0];
                    n_sidx = r_scan[IW-1:0];
                    if (!r_sfirst && r_scan == CW'(ENTRIES)) begin
                        if (n_bvalid) begin
                            n_state = S_DROP;
                            mem_ra = n_best;
                        end else begin
                            n_pend = '0; n_pend.last = 1'b1; n_pend.status = ST_NOVICT;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_DROP: begin
                mem_ra = r_best;
                n_state = S_DROPW;
            end
            S_DROPW: begin
                n_res[r_best] = 1'b0;
                n_used = r_used - {5'd0, r_rd.size};
                n_pend = '0;
                n_pend.evicted_valid = 1'b1;
                n_pend.evicted_entry = 4'(r_best);
                n_pend.used_bytes = n_used[35:0];
                n_pend.peak_bytes = r_peak[35:0];
                n_ret = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free, then transfer
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_rsp = r_pend;
                    n_rsp.used_bytes = r_used[35:0];
                    n_rsp.peak_bytes = r_peak[35:0];
                    if (r_ret) begin
                        n_ret = 1'b0; n_sstart = 1'b1; n_state = S_SCAN;
                        mem_ra = e_idx;
                    end else n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_used_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && (r_used[35:0] != 36'd0) |-> r_peak != 37'd0)
        else $error("peak below used");
    a_evict_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.evicted_valid |-> !o_rsp.last && o_rsp.status == ST_OK)
        else $error("eviction result flagged last");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall)
        else $error("accept while busy");
`endif
endmodule

FILE: dv/tb.sv
// Testbench for the budgeted residency evictor: directed table plus random requests.
`timescale 1ns / 1ps
module tb;
    import bre_pkg::*;

    localparam int NENT = 16;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_req        i_req = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_rsp        o_rsp;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [1:0]  i_cfg_data = '0;

    budgeted_residency_evictor_core #(.ENTRIES(NENT)) dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the entry table
    logic [1:0]  m_policy;
    logic        m_evict_en;
    logic        m_dep_en;
    logic        m_res [NENT];
    logic [31:0] m_size [NENT];
    logic [31:0] m_stamp [NENT];
    logic [31:0] m_count [NENT];
    logic [15:0] m_rank [NENT];
    logic [15:0] m_deps [NENT];
    logic [31:0] m_clock;
    logic [36:0] m_used;
    logic [36:0] m_peak;
    logic [31:0] m_budget;

    t_rsp exp_rsp_q [$];
    int   fail_cnt = 0;
    int   idle_cycles = 0;
    int   no_stall_phase = 0;

    function automatic logic [15:0] res_vec();
        logic [15:0] v;
        v = '0;
        for (int i = 0; i < NENT; i++) v[i] = m_res[i];
        return v;
    endfunction

    function automatic logic evictable(int i);
        if (!m_res[i]) return 1'b0;
        if (m_dep_en && ((m_deps[i] & res_vec()) != 0)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_rsp(logic [2:0] st, logic ev, logic [3:0] idx, logic lst);
        t_rsp r;
        r.status = st;
        r.evicted_valid = ev;
        r.evicted_entry = idx;
        r.used_bytes = m_used[35:0];
        r.peak_bytes = m_peak[35:0];
        r.last = lst;
        exp_rsp_q.push_back(r);
    endfunction

    // Final transfer of a request
    function automatic void push_last(logic [2:0] st);
        push_rsp(st, 1'b0, 4'd0, 1'b1);
    endfunction

    function automatic void evict_one(int i);
        m_res[i] = 1'b0;
        m_used = m_used - m_size[i];
        push_rsp(ST_OK, 1'b1, 4'(i), 1'b0);
    endfunction

    function automatic void raise_peak();
        if (m_used > m_peak) m_peak = m_used;
    endfunction

    function automatic void stamp_entry(int e);
        m_clock = m_clock + 32'd1;
        m_stamp[e] = m_clock;
        if (m_count[e] != 32'hFFFF_FFFF) m_count[e] = m_count[e] + 32'd1;
    endfunction

    function automatic int choose_victim(int skip);
        int best;
        best = -1;
        for (int i = 0; i < NENT; i++) begin
            if (i == skip || !evictable(i)) continue;
            if (best < 0) begin
                best = i;
                if (m_policy == POL_INDEX) break;
                continue;
            end
            if (m_policy == POL_OLDEST && m_stamp[i] < m_stamp[best]) best = i;
            else if (m_policy == POL_COUNT && m_count[i] < m_count[best]) best = i;
            else if (m_policy == POL_RANK && m_rank[i] < m_rank[best]) best = i;
        end
        return best;
    endfunction

    function automatic void table_reset();
        m_policy = POL_OLDEST;
        m_evict_en = 1'b1;
        m_dep_en = 1'b1;
        for (int i = 0; i < NENT; i++) begin
            m_res[i] = 1'b0; m_size[i] = '0; m_stamp[i] = '0;
            m_count[i] = '0; m_rank[i] = '0; m_deps[i] = '0;
        end
        m_clock = '0; m_used = '0; m_peak = '0;
        m_budget = RESET_BUDGET;
    endfunction

    // Append the expected transfers for one accepted request
    function automatic void predict_request(t_req q);
        int e, o, v, big_i;
        logic [31:0] big;
        logic stuck;
        e = q.entry;
        o = q.other_entry;
        stuck = 1'b0;
        case (q.req_type)
            REQ_DEFINE: begin
                if (m_res[e]) begin
                    m_used = m_used - m_size[e] + q.amount;
                    raise_peak();
                end
                m_size[e] = q.amount;
                push_last(ST_OK);
            end
            REQ_LOAD: begin
                if (m_res[e]) begin
                    stamp_entry(e);
                    push_last(ST_OK);
                end else begin
                    if (m_evict_en) begin
                        while ({1'b0, m_used} + m_size[e] > {6'd0, m_budget}) begin
                            v = choose_victim(e);
                            if (v < 0) begin stuck = 1'b1; break; end
                            evict_one(v);
                        end
                    end
                    if (stuck) push_last(ST_NOVICT);
                    else if (!q.fetch_ok) push_last(ST_FETCH);
                    else begin
                        m_res[e] = 1'b1;
                        m_used = m_used + m_size[e];
                        raise_peak();
                        stamp_entry(e);
                        push_last(ST_OK);
                    end
                end
            end
            REQ_UNLOAD: begin
                if (!m_res[e]) push_last(ST_OK);
                else if (!evictable(e)) push_last(ST_DEPS);
                else begin
                    m_res[e] = 1'b0;
                    m_used = m_used - m_size[e];
                    push_last(ST_OK);
                end
            end
            REQ_RANK: begin
                m_rank[e] = q.rank;
                push_last(ST_OK);
            end
            REQ_DEP: begin
                if (e == o) push_last(ST_BAD);
                else begin
                    m_deps[o][e] = 1'b1;
                    push_last(ST_OK);
                end
            end
            REQ_BUDGET: begin
                if (q.amount == 0) push_last(ST_ZEROBUD);
                else begin
                    while (m_used > {5'd0, q.amount}) begin
                        big_i = -1;
                        big = '0;
                        for (int i = 0; i < NENT; i++)
                            if (evictable(i) && m_size[i] > big) begin
                                big = m_size[i];
                                big_i = i;
                            end
                        if (big_i < 0) begin stuck = 1'b1; break; end
                        evict_one(big_i);
                    end
                    if (stuck) push_last(ST_NOVICT);
                    else begin
                        m_budget = q.amount;
                        push_last(ST_OK);
                    end
                end
            end
            default: push_last(ST_OK);
        endcase
    endfunction

    // Result side: random stall, compare each transfer with the oldest expectation
    initial begin
        int hold;
        t_rsp want;
        @(posedge i_rst_n);
        forever begin
            hold = (no_stall_phase != 0) ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (exp_rsp_q.size() == 0) begin
                $display("%0t unexpected result: actual %p", $time, o_rsp);
                fail_cnt++;
            end else begin
                want = exp_rsp_q.pop_front();
                if (o_rsp !== want) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, o_rsp);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Valid stays up after a transfer until the next gap or register write drops it
    task automatic send_request(t_req q);
        int gap;
        gap = (no_stall_phase != 0) ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req <= q;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(q);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [1:0] val);
        i_valid <= 1'b0;
        while (exp_rsp_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_POLICY: m_policy = val;
            CFG_EVICT:  m_evict_en = val[0];
            CFG_DEPCHK: m_dep_en = val[0];
            default: ;
        endcase
    endtask

    function automatic t_req mk(logic [2:0] rt, logic [3:0] e, logic [3:0] o,
                                logic [31:0] amt, logic [15:0] rk, logic fo);
        t_req q;
        q.req_type = rt; q.entry = e; q.other_entry = o;
        q.amount = amt; q.rank = rk; q.fetch_ok = fo;
        return q;
    endfunction

    // Random request biased toward a small working set so budgets bite
    function automatic t_req rand_request();
        t_req q;
        int pick;
        q = t_req'(60'({$urandom, $urandom}));
        q.entry = $urandom_range(0, 7) == 0 ? 4'($urandom) : 4'($urandom_range(0, 7));
        q.fetch_ok = ($urandom_range(0, 7) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 40) q.req_type = REQ_LOAD;
        else if (pick < 55) q.req_type = REQ_DEFINE;
        else if (pick < 68) q.req_type = REQ_UNLOAD;
        else if (pick < 76) q.req_type = REQ_RANK;
        else if (pick < 85) q.req_type = REQ_DEP;
        else if (pick < 95) q.req_type = REQ_BUDGET;
        else q.req_type = 3'($urandom_range(6, 7));
        if (q.req_type == REQ_DEFINE && $urandom_range(0, 9) != 0)
            q.amount = $urandom_range(1, 400);
        if (q.req_type == REQ_BUDGET && $urandom_range(0, 9) != 0)
            q.amount = $urandom_range(200, 1500);
        if (q.req_type == REQ_DEP && $urandom_range(0, 3) != 0)
            q.other_entry = 4'($urandom_range(0, 7));
        return q;
    endfunction

    t_req    dir_req [$];
    logic    dir_has [$];

    initial begin
        t_rsp r;
        table_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: expectation typed where obvious, else left to the predictor
        r = '0; r.last = 1'b1;
        dir_req = '{
            mk(REQ_BUDGET, 4'd0, 4'd0, 32'd0, 16'd0, 1'b1),
            mk(REQ_DEP, 4'd5, 4'd5, 32'd0, 16'd0, 1'b1),
            mk(3'd6, 4'd0, 4'd0, 32'd0, 16'd0, 1'b1),
            mk(3'd7, 4'd15, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 1'b0),
            mk(REQ_UNLOAD, 4'd3, 4'd0, 32'd0, 16'd0, 1'b1),
            mk(REQ_DEFINE, 4'd0, 4'd0, 32'd100, 16'd0, 1'b1),
            mk(REQ_DEFINE, 4'd1, 4'd0, 32'd200, 16'd0, 1'b1),
            mk(REQ_DEFINE, 4'd15, 4'd0, 32'hFFFF_FFFF, 16'd0, 1'b1),
            mk(REQ_RANK, 4'd0, 4'd0, 32'd0, 16'hFFFF, 1'b1),
            mk(REQ_RANK, 4'd1, 4'd0, 32'd0, 16'h0000, 1'b1),
            mk(REQ_LOAD, 4'd0, 4'd0, 32'd0, 16'd0, 1'b1),
            mk(REQ_LOAD, 4'd1, 4'd0, 32'd0, 16'd0, 1'b1),
            mk(REQ_LOAD, 4'd0, 4'd0, 32'd0, 16'd0, 1'b1),
            mk(REQ_DEP, 4'd1, 4'd0, 32'd0, 16'd0, 1'b1),
            mk(REQ_UNLOAD, 4'd0, 4'd0, 32'd0, 16'd0, 1'b1),
            mk(REQ_LOAD, 4'd15, 4'd0, 32'd0, 16'd0, 1'b0),
            mk(REQ_BUDGET, 4'd0, 4'd0, 32'd250, 16'd0, 1'b1),
            mk(REQ_BUDGET, 4'd0, 4'd0, 32'd150, 16'd0, 1'b1),
            mk(REQ_DEFINE, 4'd2, 4'd0, 32'd120, 16'd0, 1'b1),
            mk(REQ_LOAD, 4'd2, 4'd0, 32'd0, 16'd0, 1'b1),
            mk(REQ_DEFINE, 4'd2, 4'd0, 32'd90, 16'd0, 1'b1),
            mk(REQ_LOAD, 4'd15, 4'd0, 32'd0, 16'd0, 1'b1),
            mk(REQ_BUDGET, 4'd0, 4'd0, 32'hFFFF_FFFF, 16'd0, 1'b1),
            mk(REQ_LOAD, 4'd15, 4'd0, 32'd0, 16'd0, 1'b1)
        };
        dir_has = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        for (int k = 0; k < dir_req.size(); k++) begin
            send_request(dir_req[k]);
            if (dir_has[k]) begin
                r.status = (k == 0) ? ST_ZEROBUD : (k == 1) ? ST_BAD : ST_OK;
                if (exp_rsp_q[$] !== r) begin
                    $display("%0t directed row %0d: expected %p model %p",
                             $time, k, r, exp_rsp_q[$]);
                    fail_cnt++;
                end
            end
        end

        // Random phases across register settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_POLICY, 2'(ph % 4));
            write_reg(CFG_EVICT, (ph == 5) ? 2'd0 : 2'd1);
            write_reg(CFG_DEPCHK, (ph == 2 || ph == 6) ? 2'd0 : 2'd1);
            no_stall_phase = (ph == 3);
            for (int n = 0; n < 26; n++) send_request(rand_request());
        end
        no_stall_phase = 0;
        i_valid <= 1'b0;

        while (exp_rsp_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0 && exp_rsp_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
